// ===== hw/rtl/ftg_pkg.sv =====
// Shared types, constants and coefficient tables of the gait trajectory generator.
package ftg_pkg;

   // Configuration port.
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_WALK_STEP    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_OFFSET  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_AMP_OFFSET   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOMING_TICKS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOMING_STEP  = 3'd4;

   // Field widths.
   localparam int AMP_W   = 17;
   localparam int TICKS_W = 16;
   localparam int MRAD_W  = 12;

   // Shared multiplier operand and product widths.
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 28;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Series accumulator in Q14 milli-degrees.
   localparam int ACC_W  = 34;
   localparam int Q14_W  = 15;
   localparam int SIN_W  = 16;
   localparam int COEF_W = 16;
   localparam int WGT_W  = 17;

   localparam logic [Q14_W-1:0] ONE_Q14  = 15'd16384;
   localparam logic [Q14_W-1:0] POLY_C0  = 15'd25733;
   localparam logic [Q14_W-1:0] POLY_C1  = 15'd10539;
   localparam logic [Q14_W-1:0] POLY_C2  = 15'd1191;

   localparam int A0_MDEG   = 40690;
   localparam int RAD_SHIFT = 46;
   localparam int RAD_M_W   = 15;
   localparam logic [26:0] RAD_K = 27'd74961321;
   localparam int SAT_MRAD  = 2000;
   localparam int RAMP_SHIFT = 15;

   localparam int MAX_HARMONICS = 6;
   localparam int HARM_W        = 3;

   // Cosine coefficients of harmonics one to six, in milli-degrees.
   function automatic logic signed [COEF_W-1:0] cos_coef(input logic [HARM_W-1:0] k);
      logic signed [COEF_W-1:0] c;
      case (k)
         3'd0:    c = 16'sd23220;
         3'd1:    c = -16'sd4487;
         3'd2:    c = 16'sd400;
         3'd3:    c = 16'sd705;
         3'd4:    c = 16'sd1078;
         3'd5:    c = -16'sd273;
         default: c = 16'sd0;
      endcase
      return c;
   endfunction

   // Sine coefficients of harmonics one to six, in milli-degrees.
   function automatic logic signed [COEF_W-1:0] sin_coef(input logic [HARM_W-1:0] k);
      logic signed [COEF_W-1:0] c;
      case (k)
         3'd0:    c = -16'sd8650;
         3'd1:    c = 16'sd3338;
         3'd2:    c = 16'sd1389;
         3'd3:    c = 16'sd799;
         3'd4:    c = 16'sd342;
         3'd5:    c = 16'sd67;
         default: c = 16'sd0;
      endcase
      return c;
   endfunction

   typedef enum logic {
      OP_GAIT = 1'b0,
      OP_HOME = 1'b1
   } eval_op_type;

   typedef struct packed {
      logic        start;
      eval_op_type op;
   } eval_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } eval_sts_type;

endpackage

// ===== hw/rtl/ftg_mul.sv =====
// Shared signed multiplier with a registered product.
module ftg_mul
   import ftg_pkg::*;
(
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] mul_a,
   input  logic signed [MUL_B_W-1:0] mul_b,
   output logic signed [MUL_P_W-1:0] product
);

   logic signed [MUL_P_W-1:0] product_ff;
   logic signed [MUL_P_W-1:0] product_in;

   assign product_in = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== hw/rtl/ftg_eval.sv =====
// Sequencer that evaluates the gait series or the homing ramp on the shared multiplier.
module ftg_eval
   import ftg_pkg::*;
#(
   parameter int PHASE_BITS      = 32,
   parameter int SINE_TABLE_BITS = 10,
   parameter int HARMONICS       = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  eval_ctl_type             ctl,
   input  logic [PHASE_BITS-1:0]    phase,
   input  logic signed [MRAD_W-1:0] f_right,
   input  logic signed [MRAD_W-1:0] f_left,
   input  logic [AMP_W-1:0]         amp,
   output eval_sts_type             sts,
   output logic signed [MRAD_W-1:0] res_a,
   output logic signed [MRAD_W-1:0] res_b
);

   localparam int QBITS   = SINE_TABLE_BITS - 2;
   localparam int QN      = 1 << QBITS;
   localparam int X_SHIFT = 14 - QBITS;
   localparam logic signed [ACC_W-1:0] ACC_INIT = ACC_W'(A0_MDEG * 16384);

   typedef enum logic [11:0] {
      E_IDLE = 12'b000000000001,
      E_SQ   = 12'b000000000010,
      E_T1   = 12'b000000000100,
      E_T2   = 12'b000000001000,
      E_T3   = 12'b000000010000,
      E_CF   = 12'b000000100000,
      E_ACC  = 12'b000001000000,
      E_OFFS = 12'b000010000000,
      E_CV   = 12'b000100000000,
      E_FIN  = 12'b001000000000,
      E_RL   = 12'b010000000000,
      E_FH   = 12'b100000000000
   } eval_state_type;

   eval_state_type state_ff, state_in;
   logic                     done_ff, done_in;
   logic [PHASE_BITS-1:0]    ph_ff, ph_in;
   logic [PHASE_BITS-1:0]    p_ff, p_in;
   logic [HARM_W-1:0]        h_ff, h_in;
   logic                     sin_sel_ff, sin_sel_in;
   logic                     home_ff, home_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [Q14_W-1:0]         x_ff, x_in;
   logic [Q14_W-1:0]         x2_ff, x2_in;
   logic signed [WGT_W-1:0]  weight_ff, weight_in;
   logic signed [MRAD_W-1:0] f_r_ff, f_r_in;
   logic signed [MRAD_W-1:0] f_l_ff, f_l_in;
   logic                     neg_ff, neg_in;
   logic signed [MRAD_W-1:0] res_a_ff, res_a_in;
   logic signed [MRAD_W-1:0] res_b_ff, res_b_in;

   logic [SINE_TABLE_BITS-1:0] idx_base;
   logic [SINE_TABLE_BITS-1:0] idx;
   logic [1:0]                 quad;
   logic [QBITS-1:0]           rpos;
   logic [QBITS:0]             rr;
   logic [Q14_W-1:0]           x_val;
   logic [Q14_W-1:0]           prod_q14;
   logic [Q14_W-1:0]           sin_mag;
   logic signed [SIN_W-1:0]    sin_val;
   logic signed [WGT_W-1:0]    weight;
   logic signed [COEF_W-1:0]   coef;
   logic [ACC_W-1:0]           acc_mag;
   logic [RAD_M_W-1:0]         rad_m;
   logic [MRAD_W-1:0]          rad_sat;

   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [MUL_P_W-1:0]  product;

   ftg_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   // Truncation toward zero of a ramp product divided by two in Q14.
   function automatic logic signed [MRAD_W-1:0] ramp_out(input logic signed [MUL_P_W-1:0] p);
      logic [MUL_P_W-1:0] mag;
      logic [MRAD_W-1:0]  q;
      mag = p[MUL_P_W-1] ? MUL_P_W'(-p) : MUL_P_W'(p);
      q   = mag[RAMP_SHIFT +: MRAD_W];
      return p[MUL_P_W-1] ? $signed(-q) : $signed(q);
   endfunction

   // Table index of the current harmonic; cosine is a quarter turn on.
   assign idx_base = ph_ff[PHASE_BITS-1 -: SINE_TABLE_BITS];
   assign idx      = sin_sel_ff ? idx_base : idx_base + SINE_TABLE_BITS'(QN);
   assign quad     = idx[SINE_TABLE_BITS-1 -: 2];
   assign rpos     = idx[QBITS-1:0];
   assign rr       = quad[0] ? (QBITS+1)'(QN) - {1'b0, rpos} : {1'b0, rpos};
   assign x_val    = Q14_W'(rr) << X_SHIFT;

   assign prod_q14 = product[14 +: Q14_W];
   assign sin_mag  = (prod_q14 > ONE_Q14) ? ONE_Q14 : prod_q14;
   assign sin_val  = quad[1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
   assign weight   = $signed(WGT_W'(ONE_Q14)) - WGT_W'(sin_val);
   assign coef     = sin_sel_ff ? sin_coef(h_ff) : cos_coef(h_ff);
   assign acc_mag  = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);

   assign rad_m    = product[RAD_SHIFT +: RAD_M_W];
   assign rad_sat  = (rad_m > RAD_M_W'(SAT_MRAD)) ? MRAD_W'(SAT_MRAD) : rad_m[MRAD_W-1:0];

   // Operand selection of the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         E_SQ: begin
            mul_a = $signed(MUL_A_W'(x_val));
            mul_b = $signed(MUL_B_W'(x_val));
         end
         E_T1: begin
            mul_a = $signed(MUL_A_W'(prod_q14));
            mul_b = $signed(MUL_B_W'(POLY_C2));
         end
         E_T2: begin
            mul_a = $signed(MUL_A_W'(x2_ff));
            mul_b = $signed(MUL_B_W'(POLY_C1 - prod_q14));
         end
         E_T3: begin
            mul_a = $signed(MUL_A_W'(x_ff));
            mul_b = $signed(MUL_B_W'(POLY_C0 - prod_q14));
         end
         E_CF: begin
            if (home_ff) begin
               mul_a = MUL_A_W'(f_r_ff);
               mul_b = MUL_B_W'(weight);
            end else begin
               mul_a = MUL_A_W'(coef);
               mul_b = MUL_B_W'(sin_val);
            end
         end
         E_CV: begin
            mul_a = $signed(acc_mag[MUL_A_W-1:0]);
            mul_b = $signed(MUL_B_W'(RAD_K));
         end
         E_RL: begin
            mul_a = MUL_A_W'(f_l_ff);
            mul_b = MUL_B_W'(weight_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      done_in    = 1'b0;
      ph_in      = ph_ff;
      p_in       = p_ff;
      h_in       = h_ff;
      sin_sel_in = sin_sel_ff;
      home_in    = home_ff;
      acc_in     = acc_ff;
      x_in       = x_ff;
      x2_in      = x2_ff;
      weight_in  = weight_ff;
      f_r_in     = f_r_ff;
      f_l_in     = f_l_ff;
      neg_in     = neg_ff;
      res_a_in   = res_a_ff;
      res_b_in   = res_b_ff;
      if (ctl.start) begin
         // A start always wins, so that a register write can restart the series.
         state_in   = E_SQ;
         ph_in      = phase;
         p_in       = phase;
         h_in       = '0;
         sin_sel_in = 1'b0;
         home_in    = (ctl.op == OP_HOME);
         acc_in     = ACC_INIT;
         f_r_in     = f_right;
         f_l_in     = f_left;
      end else begin
         case (state_ff)
            E_IDLE: state_in = E_IDLE;
            E_SQ: begin
               x_in     = x_val;
               state_in = E_T1;
            end
            E_T1: begin
               x2_in    = prod_q14;
               state_in = E_T2;
            end
            E_T2: state_in = E_T3;
            E_T3: state_in = E_CF;
            E_CF: begin
               weight_in = weight;
               state_in  = home_ff ? E_RL : E_ACC;
            end
            E_ACC: begin
               acc_in = acc_ff + $signed(product[ACC_W-1:0]);
               if (!sin_sel_ff) begin
                  sin_sel_in = 1'b1;
                  state_in   = E_SQ;
               end else if (h_ff == HARM_W'(HARMONICS - 1)) begin
                  state_in = E_OFFS;
               end else begin
                  h_in       = h_ff + 1'b1;
                  ph_in      = ph_ff + p_ff;
                  sin_sel_in = 1'b0;
                  state_in   = E_SQ;
               end
            end
            E_OFFS: begin
               acc_in   = $signed(acc_ff - (ACC_W'(amp) << 14));
               state_in = E_CV;
            end
            E_CV: begin
               neg_in   = acc_ff[ACC_W-1];
               state_in = E_FIN;
            end
            E_FIN: begin
               res_a_in = neg_ff ? $signed(-rad_sat) : $signed(rad_sat);
               done_in  = 1'b1;
               state_in = E_IDLE;
            end
            E_RL: begin
               res_a_in = ramp_out(product);
               state_in = E_FH;
            end
            E_FH: begin
               res_b_in = ramp_out(product);
               done_in  = 1'b1;
               state_in = E_IDLE;
            end
            default: state_in = E_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ph_ff      <= ph_in;
      p_ff       <= p_in;
      h_ff       <= h_in;
      sin_sel_ff <= sin_sel_in;
      home_ff    <= home_in;
      acc_ff     <= acc_in;
      x_ff       <= x_in;
      x2_ff      <= x2_in;
      weight_ff  <= weight_in;
      f_r_ff     <= f_r_in;
      f_l_ff     <= f_l_in;
      neg_ff     <= neg_in;
      res_a_ff   <= res_a_in;
      res_b_ff   <= res_b_in;
   end

   assign sts.busy = (state_ff != E_IDLE);
   assign sts.done = done_ff;
   assign res_a    = res_a_ff;
   assign res_b    = res_b_ff;

endmodule

// ===== hw/rtl/fourier_trajectory_generator_unit.sv =====
// Top level of the Fourier-series gait trajectory generator for two joints.
//
// Each transfer on the req_ channel is one control tick; bit 0 of req_tdata is the
// run flag. Each tick gives exactly one transfer on the rsp_ channel carrying the right
// and left setpoints in milliradians, with rsp_tuser high while the homing ramp is output.
// Configuration is written through csr_we, csr_index and csr_wdata, one register per cycle.
//
// All arithmetic runs through one shared multiplier under a small sequencer, so the block
// takes one tick at a time. Each sine or cosine term runs the squaring, the polynomial and
// the coefficient product through the multiplier and is then accumulated, two terms per
// harmonic; a walking tick evaluates two series, one per joint, a homing tick one ramp pass
// for both joints and a hold tick none. The result sits in an output register, so the
// next tick may be taken while it still waits; a stalled receiver only delays the end of
// the following tick.
//
// After reset, and after every write to a defined register, the homing targets are worked
// out again from the gait at phase zero and at minus the left offset: req_tready stays low
// meanwhile. Reset is synchronous and clears the control, configuration and trajectory state.
module fourier_trajectory_generator_unit
   import ftg_pkg::*;
#(
   parameter int PHASE_BITS      = 32,
   parameter int SINE_TABLE_BITS = 10,
   parameter int HARMONICS       = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   // Tick channel. req_tdata, from bit 0: run (1), zero padding (7).
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,
   // Result channel. rsp_tdata, from bit 0: right_mrad (12), left_mrad (12).
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [23:0]            rsp_tdata,
   // rsp_tuser, from bit 0: homing (1).
   output logic                   rsp_tuser,
   // Configuration write port.
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic [8:0] {
      T_INIT_R  = 9'b000000001,
      T_INIT_RW = 9'b000000010,
      T_INIT_L  = 9'b000000100,
      T_INIT_LW = 9'b000001000,
      T_IDLE    = 9'b000010000,
      T_HOME    = 9'b000100000,
      T_WALK_R  = 9'b001000000,
      T_WALK_L  = 9'b010000000,
      T_PUSH    = 9'b100000000
   } top_state_type;

   top_state_type state_ff, state_in;

   // Configuration registers.
   logic [PHASE_BITS-1:0] walk_step_ff, walk_step_in;
   logic [PHASE_BITS-1:0] left_off_ff, left_off_in;
   logic [AMP_W-1:0]      amp_ff, amp_in;
   logic [TICKS_W-1:0]    homing_ticks_ff, homing_ticks_in;
   logic [PHASE_BITS-1:0] homing_step_ff, homing_step_in;

   // Trajectory state.
   logic [TICKS_W-1:0]       tick_count_ff, tick_count_in;
   logic [PHASE_BITS-1:0]    gait_phase_ff, gait_phase_in;
   logic [PHASE_BITS-1:0]    homing_phase_ff, homing_phase_in;
   logic signed [MRAD_W-1:0] last_r_ff, last_r_in;
   logic signed [MRAD_W-1:0] last_l_ff, last_l_in;
   logic signed [MRAD_W-1:0] target_r_ff, target_r_in;
   logic signed [MRAD_W-1:0] target_l_ff, target_l_in;

   // Finished result waiting for the output register, and the output register itself.
   logic signed [MRAD_W-1:0] pend_r_ff, pend_r_in;
   logic signed [MRAD_W-1:0] pend_l_ff, pend_l_in;
   logic                     pend_hom_ff, pend_hom_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [MRAD_W-1:0]        rsp_r_ff, rsp_r_in;
   logic [MRAD_W-1:0]        rsp_l_ff, rsp_l_in;
   logic                     rsp_hom_ff, rsp_hom_in;

   logic                     req_fire;
   logic                     homing_now;
   logic                     csr_hit;
   logic                     load_out;

   eval_ctl_type             eval_ctl;
   eval_sts_type             eval_sts;
   logic [PHASE_BITS-1:0]    eval_phase;
   logic signed [MRAD_W-1:0] eval_res_a;
   logic signed [MRAD_W-1:0] eval_res_b;

   ftg_eval #(
      .PHASE_BITS      (PHASE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .HARMONICS       (HARMONICS)
   ) u_eval (
      .clock   (clock),
      .reset   (reset),
      .ctl     (eval_ctl),
      .phase   (eval_phase),
      .f_right (target_r_ff),
      .f_left  (target_l_ff),
      .amp     (amp_ff),
      .sts     (eval_sts),
      .res_a   (eval_res_a),
      .res_b   (eval_res_b)
   );

   assign req_tready = (state_ff == T_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign homing_now = (tick_count_ff < homing_ticks_ff);
   assign load_out   = (state_ff == T_PUSH) && (!rsp_valid_ff || rsp_tready);

   // Launch of series evaluations. The left joint uses the phase lagged by the offset.
   always_comb begin
      eval_ctl.start = 1'b0;
      eval_ctl.op    = OP_GAIT;
      eval_phase     = '0;
      case (state_ff)
         T_INIT_R: begin
            eval_ctl.start = 1'b1;
         end
         T_INIT_L: begin
            eval_ctl.start = 1'b1;
            eval_phase     = '0 - left_off_ff;
         end
         T_IDLE: begin
            if (req_fire) begin
               if (homing_now) begin
                  eval_ctl.start = 1'b1;
                  eval_ctl.op    = OP_HOME;
                  eval_phase     = homing_phase_ff;
               end else if (req_tdata[0]) begin
                  eval_ctl.start = 1'b1;
                  eval_phase     = gait_phase_ff;
               end
            end
         end
         T_WALK_R: begin
            if (eval_sts.done) begin
               eval_ctl.start = 1'b1;
               eval_phase     = gait_phase_ff - left_off_ff;
            end
         end
         default: begin
            eval_ctl.start = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      walk_step_in    = walk_step_ff;
      left_off_in     = left_off_ff;
      amp_in          = amp_ff;
      homing_ticks_in = homing_ticks_ff;
      homing_step_in  = homing_step_ff;
      tick_count_in   = tick_count_ff;
      gait_phase_in   = gait_phase_ff;
      homing_phase_in = homing_phase_ff;
      last_r_in       = last_r_ff;
      last_l_in       = last_l_ff;
      target_r_in     = target_r_ff;
      target_l_in     = target_l_ff;
      pend_r_in       = pend_r_ff;
      pend_l_in       = pend_l_ff;
      pend_hom_in     = pend_hom_ff;
      rsp_r_in        = rsp_r_ff;
      rsp_l_in        = rsp_l_ff;
      rsp_hom_in      = rsp_hom_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      csr_hit         = 1'b0;

      case (state_ff)
         T_INIT_R:  state_in = T_INIT_RW;
         T_INIT_RW: begin
            if (eval_sts.done) begin
               target_r_in = eval_res_a;
               state_in    = T_INIT_L;
            end
         end
         T_INIT_L:  state_in = T_INIT_LW;
         T_INIT_LW: begin
            if (eval_sts.done) begin
               target_l_in = -eval_res_a;
               state_in    = T_IDLE;
            end
         end
         T_IDLE: begin
            if (req_fire) begin
               if (homing_now) begin
                  state_in = T_HOME;
               end else if (req_tdata[0]) begin
                  state_in = T_WALK_R;
               end else begin
                  // A hold tick repeats the last walking setpoints.
                  pend_r_in   = last_r_ff;
                  pend_l_in   = last_l_ff;
                  pend_hom_in = 1'b0;
                  state_in    = T_PUSH;
               end
            end
         end
         T_HOME: begin
            if (eval_sts.done) begin
               pend_r_in       = eval_res_a;
               pend_l_in       = eval_res_b;
               pend_hom_in     = 1'b1;
               homing_phase_in = homing_phase_ff + homing_step_ff;
               tick_count_in   = tick_count_ff + 1'b1;
               state_in        = T_PUSH;
            end
         end
         T_WALK_R: begin
            if (eval_sts.done) begin
               pend_r_in = eval_res_a;
               state_in  = T_WALK_L;
            end
         end
         T_WALK_L: begin
            if (eval_sts.done) begin
               pend_l_in     = -eval_res_a;
               pend_hom_in   = 1'b0;
               last_r_in     = pend_r_ff;
               last_l_in     = -eval_res_a;
               gait_phase_in = gait_phase_ff + walk_step_ff;
               state_in      = T_PUSH;
            end
         end
         T_PUSH: begin
            if (load_out) begin
               rsp_r_in     = pend_r_ff;
               rsp_l_in     = pend_l_ff;
               rsp_hom_in   = pend_hom_ff;
               rsp_valid_in = 1'b1;
               state_in     = T_IDLE;
            end
         end
         default: state_in = T_INIT_R;
      endcase

      if (csr_we) begin
         case (csr_index)
            CSR_WALK_STEP: begin
               walk_step_in = csr_wdata[PHASE_BITS-1:0];
               csr_hit      = 1'b1;
            end
            CSR_LEFT_OFFSET: begin
               left_off_in = csr_wdata[PHASE_BITS-1:0];
               csr_hit     = 1'b1;
            end
            CSR_AMP_OFFSET: begin
               amp_in  = csr_wdata[AMP_W-1:0];
               csr_hit = 1'b1;
            end
            CSR_HOMING_TICKS: begin
               homing_ticks_in = csr_wdata[TICKS_W-1:0];
               csr_hit         = 1'b1;
            end
            CSR_HOMING_STEP: begin
               homing_step_in = csr_wdata[PHASE_BITS-1:0];
               csr_hit        = 1'b1;
            end
            default: csr_hit = 1'b0;
         endcase
      end

      // Any defined register write makes the homing targets stale, so they are redone.
      if (csr_hit) begin
         state_in = T_INIT_R;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= T_INIT_R;
         walk_step_ff    <= PHASE_BITS'(32'd546852);
         left_off_ff     <= PHASE_BITS'(32'd2147483648);
         amp_ff          <= AMP_W'(23000);
         homing_ticks_ff <= TICKS_W'(5001);
         homing_step_ff  <= PHASE_BITS'(32'd429497);
         tick_count_ff   <= '0;
         gait_phase_ff   <= '0;
         homing_phase_ff <= '0;
         last_r_ff       <= '0;
         last_l_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         walk_step_ff    <= walk_step_in;
         left_off_ff     <= left_off_in;
         amp_ff          <= amp_in;
         homing_ticks_ff <= homing_ticks_in;
         homing_step_ff  <= homing_step_in;
         tick_count_ff   <= tick_count_in;
         gait_phase_ff   <= gait_phase_in;
         homing_phase_ff <= homing_phase_in;
         last_r_ff       <= last_r_in;
         last_l_ff       <= last_l_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // The homing targets are always rebuilt before the first tick is taken.
   always_ff @(posedge clock) begin
      target_r_ff <= target_r_in;
      target_l_ff <= target_l_in;
      pend_r_ff   <= pend_r_in;
      pend_l_ff   <= pend_l_in;
      pend_hom_ff <= pend_hom_in;
      rsp_r_ff    <= rsp_r_in;
      rsp_l_ff    <= rsp_l_in;
      rsp_hom_ff  <= rsp_hom_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_l_ff, rsp_r_ff};
   assign rsp_tuser  = rsp_hom_ff;

   // Once a tick is taken, no further tick is taken until its result has been formed.
   a_one_tick: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("tick taken while the previous tick was still being worked on");

   // The sequencer only reports a finished series to a state that is waiting for one.
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      eval_sts.done |-> (state_ff == T_INIT_R || state_ff == T_INIT_RW ||
                         state_ff == T_INIT_LW || state_ff == T_HOME ||
                         state_ff == T_WALK_R || state_ff == T_WALK_L))
      else $error("series result arrived with no evaluation outstanding");

   // A launched evaluation must leave the idle state of the sequencer.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      eval_ctl.start |=> eval_sts.busy)
      else $error("series evaluation did not start");

   // Both setpoints leave the block saturated.
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($signed(rsp_r_ff) <= 12'sd2000 && $signed(rsp_r_ff) >= -12'sd2000 &&
                        $signed(rsp_l_ff) <= 12'sd2000 && $signed(rsp_l_ff) >= -12'sd2000))
      else $error("setpoint outside the saturation limits");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the two-joint Fourier gait trajectory generator.
module tb_top;
   import ftg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Sine table geometry of the block: ten index bits, a quarter wave of 256 entries.
   localparam int QUARTER_BITS = 8;
   localparam int QUARTER_LEN  = 1 << QUARTER_BITS;

   // No transfer of any kind for this many cycles means the block has hung. This leaves a
   // wide margin over a walking tick and over the target refresh after a write, even under
   // the heaviest receiver stalls.
   localparam int QUIET_LIMIT = 5000;

   // Cycles allowed after the last expected transfer before the verdict is given.
   localparam int DRAIN_CYCLES = 300;

   // Register indexes at and above this one are not defined and must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_UNUSED = CSR_HOMING_STEP + 3'd1;

   typedef enum logic [1:0] {
      PACE_FULL,
      PACE_SENDER_IDLE,
      PACE_RECEIVER_STALL,
      PACE_BOTH_IDLE
   } pacing_type;

   typedef struct packed {
      logic signed [MRAD_W-1:0] right_mrad;
      logic signed [MRAD_W-1:0] left_mrad;
      logic                     homing;
   } setpoint_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [23:0]            rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Run flags waiting to be offered, and the setpoints that accepted ticks still owe.
   logic         ticks_to_send [$];
   setpoint_type setpoints_due [$];

   pacing_type pacing = PACE_FULL;
   int         mismatch_count = 0;
   int         quiet_cycles = 0;

   // Our own copy of the registers and of the generator state.
   logic [31:0]              walk_step, left_offset, homing_step;
   logic [AMP_W-1:0]         amp_offset;
   logic [TICKS_W-1:0]       homing_len, ticks_done;
   logic [31:0]              walk_phase, home_phase;
   logic signed [MRAD_W-1:0] held_right, held_left, target_right, target_left;

   // Harmonic weights in milli-degrees, harmonics one to six.
   int cos_mdeg [6] = '{23220, -4487, 400, 705, 1078, -273};
   int sin_mdeg [6] = '{-8650, 3338, 1389, 799, 342, 67};

   fourier_trajectory_generator_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------

   // Quarter-wave sine in Q14 from the odd polynomial, with every product truncated.
   function automatic int quarter_wave(input int unsigned pos);
      longint unsigned x, x2, t;
      x  = {32'd0, pos} << (14 - QUARTER_BITS);
      x2 = (x * x) >> 14;
      t  = 10539 - ((x2 * 1191) >> 14);
      t  = 25733 - ((x2 * t) >> 14);
      t  = (x * t) >> 14;
      if (t > 16384) t = 16384;
      return int'(t);
   endfunction

   // Full-wave sine in Q14 from a ten-bit table index, folded from the quarter wave.
   function automatic int sine_q14(input logic [9:0] idx);
      int v;
      v = idx[8] ? quarter_wave(QUARTER_LEN - idx[7:0]) : quarter_wave(idx[7:0]);
      return idx[9] ? -v : v;
   endfunction

   // The gait series at one phase, less the amplitude offset, in saturated milliradians.
   function automatic logic signed [MRAD_W-1:0] gait_setpoint(input logic [31:0] phase);
      longint          acc, mrad;
      longint unsigned mag;
      logic [31:0]     harm_phase;
      logic [9:0]      idx;
      acc = longint'(A0_MDEG) * 16384;
      for (int k = 0; k < 6; k++) begin
         harm_phase = phase * (k + 1);
         idx = harm_phase[31:22];
         acc += cos_mdeg[k] * sine_q14(idx + 10'd256) + sin_mdeg[k] * sine_q14(idx);
      end
      acc -= longint'(amp_offset) * 16384;
      mag  = (acc < 0) ? -acc : acc;
      mag  = (mag * 64'd74961321) >> 46;
      mrad = (acc < 0) ? -longint'(mag) : longint'(mag);
      if (mrad > SAT_MRAD) mrad = SAT_MRAD;
      if (mrad < -SAT_MRAD) mrad = -SAT_MRAD;
      return MRAD_W'(mrad);
   endfunction

   // Raised-cosine homing value, truncated toward zero.
   function automatic logic signed [MRAD_W-1:0] ramp_toward(input logic signed [MRAD_W-1:0] f,
                                                           input int c);
      longint prod, mag;
      prod = longint'(f) * (16384 - c);
      mag  = ((prod < 0) ? -prod : prod) / 32768;
      return MRAD_W'((prod < 0) ? -mag : mag);
   endfunction

   function automatic void refresh_targets();
      target_right = gait_setpoint(32'd0);
      target_left  = -gait_setpoint(32'd0 - left_offset);
   endfunction

   function automatic void restore_defaults();
      walk_step   = 32'd546852;
      left_offset = 32'h8000_0000;
      amp_offset  = 17'd23000;
      homing_len  = 16'd5001;
      homing_step = 32'd429497;
      ticks_done  = '0;
      walk_phase  = '0;
      home_phase  = '0;
      held_right  = '0;
      held_left   = '0;
      refresh_targets();
   endfunction

   function automatic void apply_register(input logic [CSR_INDEX_W-1:0] index,
                                          input logic [CSR_DATA_W-1:0] value);
      case (index)
         CSR_WALK_STEP:    walk_step   = value;
         CSR_LEFT_OFFSET:  left_offset = value;
         CSR_AMP_OFFSET:   amp_offset  = value[AMP_W-1:0];
         CSR_HOMING_TICKS: homing_len  = value[TICKS_W-1:0];
         CSR_HOMING_STEP:  homing_step = value;
         default:          return;
      endcase
      refresh_targets();
   endfunction

   // Works out the setpoint owed by one accepted tick and moves our state on.
   function automatic void predict_tick(input logic run);
      setpoint_type sp;
      int           c;
      sp.homing = 1'b0;
      if (ticks_done < homing_len) begin
         // While homing the run flag is ignored; the current phase is used before it moves.
         c = sine_q14(home_phase[31:22] + 10'd256);
         sp.right_mrad = ramp_toward(target_right, c);
         sp.left_mrad  = ramp_toward(target_left, c);
         sp.homing     = 1'b1;
         home_phase += homing_step;
         ticks_done += 1'b1;
      end else if (run) begin
         sp.right_mrad = gait_setpoint(walk_phase);
         sp.left_mrad  = -gait_setpoint(walk_phase - left_offset);
         held_right    = sp.right_mrad;
         held_left     = sp.left_mrad;
         walk_phase   += walk_step;
      end else begin
         // Holding repeats the last walking setpoints, which are zero before any walk.
         sp.right_mrad = held_right;
         sp.left_mrad  = held_left;
      end
      setpoints_due.push_back(sp);
   endfunction

   // ---------------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------------

   // Every mismatch is counted; the printing is capped so that a badly broken block
   // cannot flood the log.
   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 100) $display("tb_top: %0t ns: %s", $time, what);
   endtask

   task automatic check_setpoint(input logic [23:0] data, input logic homing);
      setpoint_type sp;
      if (setpoints_due.size() == 0) begin
         report_mismatch($sformatf("setpoint transfer %h/%b with no tick outstanding",
                                   data, homing));
      end else begin
         sp = setpoints_due.pop_front();
         if (data[MRAD_W-1:0] !== sp.right_mrad)
            report_mismatch($sformatf("right setpoint %0d, expected %0d",
                                      $signed(data[MRAD_W-1:0]), sp.right_mrad));
         if (data[2*MRAD_W-1:MRAD_W] !== sp.left_mrad)
            report_mismatch($sformatf("left setpoint %0d, expected %0d",
                                      $signed(data[2*MRAD_W-1:MRAD_W]), sp.left_mrad));
         if (homing !== sp.homing)
            report_mismatch($sformatf("homing flag %b, expected %b", homing, sp.homing));
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Pacing of both sides
   // ---------------------------------------------------------------------------------

   function automatic bit sender_ready();
      case (pacing)
         PACE_SENDER_IDLE: return $urandom_range(0, 99) >= 85;
         PACE_BOTH_IDLE:   return $urandom_range(0, 99) >= 17;
         default:          return 1'b1;
      endcase
   endfunction

   function automatic bit receiver_ready();
      case (pacing)
         PACE_RECEIVER_STALL: return $urandom_range(0, 99) >= 85;
         PACE_BOTH_IDLE:      return $urandom_range(0, 99) >= 17;
         default:             return 1'b1;
      endcase
   endfunction

   // Tick driver. A tick is predicted at the edge where its transfer completes; a new one
   // is offered only once the previous one has gone, so valid is assigned once per edge.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_tick(req_tdata[0]);
         if (!req_tvalid || req_tready) begin
            if (ticks_to_send.size() != 0 && sender_ready()) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {7'b0, ticks_to_send.pop_front()};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Setpoint monitor. The values sampled at the edge are those of the completed transfer.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_setpoint(rsp_tdata, rsp_tuser);
         rsp_tready <= receiver_ready();
      end
   end

   // Watchdog: any transfer, or a register write, counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: no transfer for %0d cycles, giving up", QUIET_LIMIT);
         $display("tb_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------

   // Register writes happen only when the block is idle, so our copy can be updated
   // at once. The block refreshes its homing targets afterwards and holds off ticks
   // meanwhile, which the driver simply waits out.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      apply_register(index, value);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Returns once no tick is waiting or in flight and every setpoint has been received.
   task automatic wait_idle();
      do @(negedge clock);
      while (ticks_to_send.size() != 0 || req_tvalid || setpoints_due.size() != 0);
   endtask

   // Queues a directed run pattern, bit 0 first.
   task automatic queue_runs(input logic [15:0] runs, input int count);
      @(negedge clock);
      for (int i = 0; i < count; i++) ticks_to_send.push_back(runs[i]);
   endtask

   // Random ticks, mostly walking with a fair share of holds.
   task automatic queue_ticks(input int count);
      @(negedge clock);
      repeat (count) ticks_to_send.push_back($urandom_range(0, 3) != 0);
   endtask

   // Phase words favour the extremes and small steps that give a smooth gait.
   function automatic logic [31:0] phase_word();
      case ($urandom_range(0, 4))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom_range(1, 1 << 22);
         default: return $urandom();
      endcase
   endfunction

   // Amplitude offsets, including values beyond the usual range and junk above bit 16.
   function automatic logic [31:0] amp_word();
      logic [AMP_W-1:0] v;
      case ($urandom_range(0, 5))
         0:       v = '0;
         1:       v = 17'd90000;
         2:       v = AMP_W'($urandom_range(90001, 131071));
         default: v = AMP_W'($urandom_range(0, 90000));
      endcase
      return {15'($urandom()), v};
   endfunction

   // Homing lengths relative to the ticks already taken: a few more homing ticks, none,
   // or occasionally the longest ramp.
   function automatic logic [31:0] homing_len_word();
      logic [TICKS_W-1:0] v;
      case ($urandom_range(0, 11))
         0:       v = '0;
         1:       v = 16'hFFFF;
         2, 3, 4: v = ticks_done + 16'($urandom_range(1, 5));
         default: v = TICKS_W'($urandom_range(0, ticks_done));
      endcase
      return {16'($urandom()), v};
   endfunction

   initial begin
      restore_defaults();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      // Homing under the reset registers; the run flag must make no difference.
      queue_runs(16'b0101, 4);
      wait_idle();

      // Two more homing ticks at quarter-turn steps, then holds before any walking tick
      // (which must give zero), walking, and a hold of the walked values.
      csr_write(CSR_HOMING_TICKS, 32'd6);
      csr_write(CSR_HOMING_STEP, 32'h4000_0000);
      queue_runs(16'b0110010, 7);
      wait_idle();

      // No amplitude offset, no left lag and the largest walking step.
      csr_write(CSR_AMP_OFFSET, 32'd0);
      csr_write(CSR_LEFT_OFFSET, 32'd0);
      csr_write(CSR_WALK_STEP, 32'hFFFF_FFFF);
      queue_runs(16'b0111, 4);
      wait_idle();

      // An all-ones write masks to the largest amplitude offset, far beyond the usual
      // range. The gait phase stands still.
      csr_write(CSR_AMP_OFFSET, 32'hFFFF_FFFF);
      csr_write(CSR_LEFT_OFFSET, 32'hFFFF_FFFF);
      csr_write(CSR_WALK_STEP, 32'd0);
      queue_runs(16'b101, 3);
      wait_idle();

      // Homing again with fresh targets and the largest homing step; the writes to
      // undefined indexes in between must change nothing.
      csr_write(CSR_AMP_OFFSET, 32'd90000);
      csr_write(CSR_HOMING_STEP, 32'hFFFF_FFFF);
      for (int i = CSR_FIRST_UNUSED; i < (1 << CSR_INDEX_W); i++)
         csr_write(CSR_INDEX_W'(i), $urandom());
      csr_write(CSR_HOMING_TICKS, {16'd0, ticks_done + 16'd3});
      queue_runs(16'b10111, 5);
      wait_idle();

      // A zero homing length skips homing altogether.
      csr_write(CSR_HOMING_TICKS, 32'd0);
      csr_write(CSR_WALK_STEP, 32'd546852);
      queue_runs(16'b01, 2);
      wait_idle();

      // Random phases. Pacing cycles through full rate, an idle sender, a stalling
      // receiver and both idling lightly. In one phase the sender stops half way until
      // every outstanding setpoint has arrived.
      for (int phase = 0; phase < 15; phase++) begin
         pacing = pacing_type'(phase % 4);
         if ($urandom_range(0, 1)) csr_write(CSR_WALK_STEP, phase_word());
         if ($urandom_range(0, 1)) csr_write(CSR_LEFT_OFFSET, phase_word());
         if ($urandom_range(0, 1)) csr_write(CSR_HOMING_STEP, phase_word());
         if ($urandom_range(0, 1)) csr_write(CSR_AMP_OFFSET, amp_word());
         csr_write(CSR_HOMING_TICKS, homing_len_word());
         if (phase == 5) begin
            queue_ticks(21);
            wait_idle();
            queue_ticks(21);
         end else begin
            queue_ticks(42);
         end
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (setpoints_due.size() != 0)
         report_mismatch($sformatf("%0d setpoints never arrived", setpoints_due.size()));
      if (mismatch_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/ftg_pkg.sv
hw/rtl/ftg_mul.sv
hw/rtl/ftg_eval.sv
hw/rtl/fourier_trajectory_generator_unit.sv
dv/tb_top.sv
